>>> hdl/gif_aee_pkg.sv
package gif_aee_pkg;

    // Fixed field widths of the stream, result and configuration transfers, and the default length width.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LENGTH_W    = 32;
    localparam int unsigned COUNT_W     = 10;
    localparam int unsigned ID_HEAD_W   = 64;
    localparam int unsigned ID_TAIL_W   = 24;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned LENGTH_BITS_DEF = 32;

    // GIF framing constants.
    localparam logic [BYTE_W-1:0]  EXT_INTRO      = 8'h21;
    localparam logic [BYTE_W-1:0]  APP_LABEL      = 8'hFF;
    localparam logic [BYTE_W-1:0]  APP_BLOCK_SIZE = 8'd11;
    localparam logic [COUNT_W-1:0] FIELD_INDEX    = 10'd10;
    // Header bytes still to come after the packed field byte.
    localparam logic [COUNT_W-1:0] HEADER_REST    = 10'd2;
    localparam logic [COUNT_W-1:0] ENTRY_BYTES    = 10'd3;

    // Configuration register indexes.
    typedef enum logic {
        CFG_ID_HEAD = 1'b0,
        CFG_ID_TAIL = 1'b1
    } t_cfg_index;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_SKIPHDR = 4'd1,
        PH_INTRO   = 4'd2,
        PH_LABEL   = 4'd3,
        PH_BSIZE   = 4'd4,
        PH_IDENT   = 4'd5,
        PH_SSUBLEN = 4'd6,
        PH_SSUB    = 4'd7,
        PH_MSUBLEN = 4'd8,
        PH_MSUB    = 4'd9,
        PH_DONE    = 4'd10
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_COMPLETE  = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              file_start;
    } t_in_item;

    typedef struct packed {
        t_kind               result_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LENGTH_W-1:0] payload_length;
    } t_out_item;

endpackage

>>> hdl/gif_app_extension_extractor_unit.sv
// GIF application extension extractor. The block takes one file byte per transfer and can
// accept a byte in every cycle; each byte gives at most one result, which is registered into
// the output register or, while the output is stalled, into a one-entry skid stage behind it
// that holds one more result, so the input keeps flowing; the input stalls only while that
// skid stage is full. The rate is set by the byte-wise parser state machine, which handles a
// whole byte in one cycle. The user must write the identifier registers through the plain
// write port only while no file is being parsed; the block itself does not enforce this.
module gif_app_extension_extractor_unit #(
    parameter int unsigned LENGTH_BITS = gif_aee_pkg::LENGTH_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Byte stream
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gif_aee_pkg::t_in_item             i_in_data,
    // Results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gif_aee_pkg::t_out_item            o_out_data,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [gif_aee_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import gif_aee_pkg::*;

    // The running total saturates at the smaller of its own width and the result field.
    localparam int unsigned TOTAL_W = (LENGTH_BITS < LENGTH_W) ? LENGTH_BITS : LENGTH_W;
    localparam int unsigned ID_W    = ID_HEAD_W + ID_TAIL_W;

    logic [ID_HEAD_W-1:0] r_id_head;
    logic [ID_TAIL_W-1:0] r_id_tail;

    t_phase               r_phase,  n_phase;
    logic [COUNT_W-1:0]   r_count,  n_count;
    logic                 r_equal,  n_equal;
    logic [TOTAL_W-1:0]   r_total,  n_total;

    t_phase               cur_phase;
    logic [COUNT_W-1:0]   cur_count;
    logic                 cur_equal;
    logic [TOTAL_W-1:0]   cur_total;

    logic                 in_accept;
    logic                 out_free;
    logic                 res_valid;
    t_out_item            res_item;
    logic [BYTE_W-1:0]    in_byte;
    logic [BYTE_W-1:0]    id_byte;
    logic [ID_W-1:0]      id_vec;
    logic [3:0]           id_sel;

    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 r_skid_valid;
    t_out_item            r_skid_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_head <= '0;
            r_id_tail <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ID_HEAD: r_id_head <= i_cfg_data;
                CFG_ID_TAIL: r_id_tail <= i_cfg_data[ID_TAIL_W-1:0];
                default:     r_id_head <= r_id_head;
            endcase
        end
    end

    // Handshake on the input side.
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_byte    = i_in_data.data_byte;

    // A file start restarts the parser before the byte is handled.
    always_comb begin
        if (i_in_data.file_start) begin
            cur_phase = PH_HEAD;
            cur_count = '0;
            cur_equal = 1'b1;
            cur_total = '0;
        end else begin
            cur_phase = r_phase;
            cur_count = r_count;
            cur_equal = r_equal;
            cur_total = r_total;
        end
    end

    // Identifier byte to compare: the count runs from the block size, eleven for a match, down to one.
    assign id_vec = {r_id_head, r_id_tail};
    assign id_sel = cur_count[3:0] - 4'd1;

    always_comb begin
        if (id_sel <= 4'd10) begin
            id_byte = id_vec[{id_sel, 3'b000} +: BYTE_W];
        end else begin
            id_byte = '0;
        end
    end

    // Parser next state.
    always_comb begin
        n_phase = cur_phase;
        n_count = cur_count;
        n_equal = cur_equal;
        n_total = cur_total;
        unique case (cur_phase)
            PH_HEAD: begin
                if (cur_count == FIELD_INDEX) begin
                    if (in_byte[7]) begin
                        n_count = HEADER_REST
                                + (ENTRY_BYTES << ({1'b0, in_byte[2:0]} + 4'd1));
                    end else begin
                        n_count = HEADER_REST;
                    end
                    n_phase = PH_SKIPHDR;
                end else begin
                    n_count = cur_count + COUNT_W'(1);
                end
            end
            PH_SKIPHDR: begin
                if (cur_count > COUNT_W'(1)) begin
                    n_count = cur_count - COUNT_W'(1);
                end else begin
                    n_count = '0;
                    n_phase = PH_INTRO;
                end
            end
            PH_INTRO: begin
                if (in_byte != EXT_INTRO) begin
                    n_phase = PH_DONE;
                end else begin
                    n_equal = 1'b1;
                    n_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                n_equal = cur_equal && (in_byte == APP_LABEL);
                n_phase = PH_BSIZE;
            end
            PH_BSIZE: begin
                n_equal = cur_equal && (in_byte == APP_BLOCK_SIZE);
                n_count = COUNT_W'(in_byte);
                n_phase = (in_byte == '0) ? PH_SSUBLEN : PH_IDENT;
            end
            PH_IDENT: begin
                n_equal = cur_equal && (in_byte == id_byte);
                n_count = cur_count - COUNT_W'(1);
                if (cur_count == COUNT_W'(1)) begin
                    n_phase = n_equal ? PH_MSUBLEN : PH_SSUBLEN;
                end
            end
            PH_SSUBLEN: begin
                if (in_byte == '0) begin
                    n_phase = PH_INTRO;
                end else begin
                    n_count = COUNT_W'(in_byte);
                    n_phase = PH_SSUB;
                end
            end
            PH_SSUB: begin
                n_count = cur_count - COUNT_W'(1);
                if (cur_count == COUNT_W'(1)) begin
                    n_phase = PH_SSUBLEN;
                end
            end
            PH_MSUBLEN: begin
                if (in_byte == '0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_count = COUNT_W'(in_byte);
                    n_phase = PH_MSUB;
                end
            end
            PH_MSUB: begin
                if (cur_total != '1) begin
                    n_total = cur_total + TOTAL_W'(1);
                end
                n_count = cur_count - COUNT_W'(1);
                if (cur_count == COUNT_W'(1)) begin
                    n_phase = PH_MSUBLEN;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Result produced by the accepted byte.
    always_comb begin
        res_valid               = 1'b0;
        res_item.result_kind    = KIND_PAYLOAD;
        res_item.payload_byte   = '0;
        res_item.payload_length = '0;
        unique case (cur_phase)
            PH_INTRO: begin
                if (in_byte != EXT_INTRO) begin
                    res_valid            = 1'b1;
                    res_item.result_kind = KIND_NOT_FOUND;
                end
            end
            PH_MSUBLEN: begin
                if (in_byte == '0) begin
                    res_valid               = 1'b1;
                    res_item.result_kind    = KIND_COMPLETE;
                    res_item.payload_length = LENGTH_W'(cur_total);
                end
            end
            PH_MSUB: begin
                res_valid             = 1'b1;
                res_item.payload_byte = in_byte;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_count <= '0;
            r_equal <= 1'b1;
            r_total <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_equal <= n_equal;
            r_total <= n_total;
        end
    end

    // Output register and skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_item <= r_skid_item;
            end
        end else if (in_accept && res_valid) begin
            if (out_free) begin
                r_out_item <= res_item;
            end else begin
                r_skid_item <= res_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // The skid stage only fills behind a held output transfer.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    // Once finished, only a file start brings new results.
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_DONE && !i_in_data.file_start) |-> !res_valid)
        else $error("result produced after the parse finished");

    // A sub-block body is never entered with nothing left to read.
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MSUB || r_phase == PH_SSUB || r_phase == PH_IDENT)
            |-> (r_count != '0))
        else $error("byte count exhausted inside a block body");

    // A byte accepted into a full output side must land in the skid stage.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result lost behind a stalled output");

endmodule
